### src/dcbs_pkg.sv
// Shared constants and register codes for the drift channel bit simulator.
`default_nettype none

package dcbs_pkg;

  // Default limits on how far the drift may lead or lag.
  localparam int MAX_LEAD_DEF = 8;
  localparam int MAX_LAG_DEF  = 8;

  // Fixed field widths.
  localparam int PROB_W  = 16;
  localparam int LIMIT_W = 4;
  localparam int DRIFT_W = 5;
  // The flush index never exceeds the magnitude of a 4-bit signed limit.
  localparam int EIDX_W  = 4;

  // Configuration port.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int RIDX_W = 3;

  // Register indexes (byte address divided by four).
  localparam logic [RIDX_W-1:0] REG_DRIFT_MIN      = 3'd0;
  localparam logic [RIDX_W-1:0] REG_DRIFT_MAX      = 3'd1;
  localparam logic [RIDX_W-1:0] REG_PROB_DELETE    = 3'd2;
  localparam logic [RIDX_W-1:0] REG_PROB_INSERT    = 3'd3;
  localparam logic [RIDX_W-1:0] REG_PROB_SUBST     = 3'd4;
  localparam logic [RIDX_W-1:0] REG_PROB_SUBST_INS = 3'd5;

endpackage

`default_nettype wire

### src/drift_channel_bit_simulator.sv
// Top level of the Markov drift insertion/deletion channel bit simulator.
//
// Input channel (in_valid/in_stall) takes one sent bit of a block per beat,
// with its random draws and a block_end mark on the final bit. Output channel
// (out_valid/out_stall) delivers received bits with the drift used, the error
// flag and a last_of_block mark.
// Each input beat updates the drift walk and the delay lines at once; its
// results are then built from those lines and held in the output register.
// An ordinary beat gives at most one result, and one beat is taken per
// cycle while the receiver does not stall. A beat with block_end set gives
// up to 1 - drift_min results, one a cycle while the receiver does not
// stall, and the input is stalled until the last of them has entered the
// output register; that flush and receiver stalls make the only gaps.
// No result is given for the first -drift_min bits of a block.
// Reset clears the drift, the position count and the registers to their
// defaults; the delay lines are refilled by the bits that follow.
// When the receiver stalls, the output register holds its beat and the
// input is stalled as soon as a further result has nowhere to go.
`default_nettype none

module drift_channel_bit_simulator
  import dcbs_pkg::*;
#(
  parameter int MAX_LEAD = MAX_LEAD_DEF,
  parameter int MAX_LAG  = MAX_LAG_DEF
) (
  input  wire                       clk,
  input  wire                       rst,
  // Configuration port.
  input  wire                       psel,
  input  wire                       penable,
  input  wire                       pwrite,
  input  wire  [ADDR_W-1:0]         paddr,
  input  wire  [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  // Input channel.
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire                       sent_bit,
  input  wire  [PROB_W-1:0]         rand_drift,
  input  wire  [PROB_W-1:0]         rand_error,
  input  wire                       rand_prior,
  input  wire                       block_end,
  // Output channel.
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic                      recv_bit,
  output logic signed [DRIFT_W-1:0] drift_state,
  output logic                      error_applied,
  output logic                      last_of_block
);

  localparam int DLY_DEPTH = MAX_LAG + 1;
  localparam int WIN_DEPTH = MAX_LEAD + MAX_LAG + 1;
  localparam int DLY_IW    = (DLY_DEPTH > 1) ? $clog2(DLY_DEPTH) : 1;
  localparam int WIN_IW    = $clog2(WIN_DEPTH);
  localparam int PC_W      = $clog2(WIN_DEPTH + 1);
  localparam int CW        = ((PC_W > 5) ? PC_W : 5) + 2;

  localparam logic signed [CW-1:0] LAG_LIM  = -(CW'(MAX_LAG));
  localparam logic signed [CW-1:0] LEAD_LIM = CW'(MAX_LEAD);
  localparam logic signed [CW-1:0] WIN_LIM  = CW'(WIN_DEPTH);
  localparam logic [PC_W-1:0]      PC_SAT   = PC_W'(WIN_DEPTH);

  // Configuration registers.
  logic signed [LIMIT_W-1:0] drift_min;
  logic [LIMIT_W-1:0]        drift_max;
  logic [PROB_W-1:0]         prob_delete;
  logic [PROB_W-1:0]         prob_insert;
  logic [PROB_W-1:0]         prob_subst;
  logic [PROB_W-1:0]         prob_subst_ins;

  // Channel state.
  logic signed [DRIFT_W-1:0] prev_drift;
  logic [PC_W-1:0]           pos_count;
  logic                      seen_last;
  logic signed [DRIFT_W-1:0] drift_dly [DLY_DEPTH];
  logic                      error_dly [DLY_DEPTH];
  logic                      prior_dly [DLY_DEPTH];
  logic [WIN_DEPTH-1:0]      sent_win;

  // Result sequencing.
  logic                      pend;
  logic [EIDX_W-1:0]         eidx;

  logic                      cfg_wr;
  logic [RIDX_W-1:0]         reg_idx;
  logic                      in_take;
  logic                      out_free;
  logic                      emit_last;

  logic signed [CW-1:0]      zmin;
  logic signed [CW-1:0]      zmax;
  logic signed [CW-1:0]      zbase;
  logic signed [CW-1:0]      zp;
  logic signed [CW-1:0]      zstep;
  logic signed [CW-1:0]      znew;
  logic [PROB_W:0]           prob_sum;
  logic                      rose;
  logic                      err_new;
  logic [PC_W-1:0]           pc_base;
  logic [PC_W-1:0]           pc_next;

  logic signed [CW-1:0]      emax;
  logic signed [CW-1:0]      e_s;
  logic signed [CW-1:0]      dd;
  logic signed [CW-1:0]      pc_s;
  logic signed [CW-1:0]      zi_s;
  logic signed [CW-1:0]      dpos;
  logic signed [DRIFT_W-1:0] zi;
  logic                      fl;
  logic                      prior_sel;
  logic                      hit;
  logic                      bit_sel;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Register read-back.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_DRIFT_MIN:      prdata = DATA_W'(drift_min[LIMIT_W-1:0]);
      REG_DRIFT_MAX:      prdata = DATA_W'(drift_max);
      REG_PROB_DELETE:    prdata = DATA_W'(prob_delete);
      REG_PROB_INSERT:    prdata = DATA_W'(prob_insert);
      REG_PROB_SUBST:     prdata = DATA_W'(prob_subst);
      REG_PROB_SUBST_INS: prdata = DATA_W'(prob_subst_ins);
      default:            prdata = '0;
    endcase
  end

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      drift_min      <= '0;
      drift_max      <= LIMIT_W'(1);
      prob_delete    <= '0;
      prob_insert    <= '0;
      prob_subst     <= '0;
      prob_subst_ins <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DRIFT_MIN:      drift_min      <= pwdata[LIMIT_W-1:0];
        REG_DRIFT_MAX:      drift_max      <= pwdata[LIMIT_W-1:0];
        REG_PROB_DELETE:    prob_delete    <= pwdata[PROB_W-1:0];
        REG_PROB_INSERT:    prob_insert    <= pwdata[PROB_W-1:0];
        REG_PROB_SUBST:     prob_subst     <= pwdata[PROB_W-1:0];
        REG_PROB_SUBST_INS: prob_subst_ins <= pwdata[PROB_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective drift limits, clamped to the delay lines and the sent-bit window.
  always_comb begin
    zmin = {{(CW-LIMIT_W){drift_min[LIMIT_W-1]}}, drift_min};
    if (zmin < LAG_LIM) begin
      zmin = LAG_LIM;
    end
    if (zmin > 0) begin
      zmin = '0;
    end
    zmax = {{(CW-LIMIT_W){1'b0}}, drift_max};
    if (zmax > LEAD_LIM) begin
      zmax = LEAD_LIM;
    end
  end

  // Drift walk: a block boundary restarts it at zero.
  always_comb begin
    zbase = seen_last ? '0 : {{(CW-DRIFT_W){prev_drift[DRIFT_W-1]}}, prev_drift};
    zp    = zbase;
    if (zp < zmin) begin
      zp = zmin;
    end
    if (zp > zmax) begin
      zp = zmax;
    end
    prob_sum = {1'b0, prob_insert} + {1'b0, prob_delete};
    if (zp == zmax) begin
      zstep = (rand_drift < prob_delete) ? zp - CW'(1) : zp;
    end else if (zp == zmin) begin
      zstep = (rand_drift < prob_insert) ? zp + CW'(1) : zp;
    end else if (rand_drift < prob_insert) begin
      zstep = zp + CW'(1);
    end else if ({1'b0, rand_drift} < prob_sum) begin
      zstep = zp - CW'(1);
    end else begin
      zstep = zp;
    end
    znew = zstep;
    if (znew < zmin) begin
      znew = zmin;
    end
    if (znew > zmax) begin
      znew = zmax;
    end
    rose    = znew > zp;
    err_new = rose ? (rand_error < prob_subst_ins) : (rand_error < prob_subst);
    pc_base = seen_last ? '0 : pos_count;
    pc_next = (pc_base < PC_SAT) ? pc_base + PC_W'(1) : pc_base;
  end

  // Result selection for flush index eidx, from the lines as the last beat left them.
  always_comb begin
    emax      = seen_last ? -zmin : '0;
    e_s       = {{(CW-EIDX_W){1'b0}}, eidx};
    dd        = -zmin - e_s;
    pc_s      = {{(CW-PC_W){1'b0}}, pos_count};
    hit       = dd < pc_s;
    zi        = drift_dly[dd[DLY_IW-1:0]];
    fl        = error_dly[dd[DLY_IW-1:0]];
    prior_sel = prior_dly[dd[DLY_IW-1:0]];
    zi_s      = {{(CW-DRIFT_W){zi[DRIFT_W-1]}}, zi};
    dpos      = zi_s - zmin - e_s;
    if (dpos < 0) begin
      bit_sel = sent_win[0];
    end else if (dpos >= pc_s || dpos >= WIN_LIM) begin
      bit_sel = prior_sel;
    end else begin
      bit_sel = sent_win[dpos[WIN_IW-1:0]];
    end
  end

  // Handshake: a new beat enters once the pending results are all placed.
  assign out_free  = !out_valid || !out_stall;
  assign emit_last = (e_s == emax);
  assign in_stall  = pend && !(out_free && emit_last);
  assign in_take   = in_valid && !in_stall;

  // Delay lines and sent-bit window, newest at index 0.
  always_ff @(posedge clk) begin
    if (in_take) begin
      for (int i = DLY_DEPTH - 1; i > 0; i--) begin
        drift_dly[i] <= drift_dly[i-1];
        error_dly[i] <= error_dly[i-1];
        prior_dly[i] <= prior_dly[i-1];
      end
      drift_dly[0] <= znew[DRIFT_W-1:0];
      error_dly[0] <= err_new;
      prior_dly[0] <= rand_prior;
      sent_win     <= {sent_win[WIN_DEPTH-2:0], sent_bit};
    end
  end

  // Walk state and result sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_drift <= '0;
      pos_count  <= '0;
      seen_last  <= 1'b0;
      pend       <= 1'b0;
      eidx       <= '0;
    end else if (in_take) begin
      prev_drift <= znew[DRIFT_W-1:0];
      pos_count  <= pc_next;
      seen_last  <= block_end;
      pend       <= 1'b1;
      eidx       <= '0;
    end else if (pend && out_free) begin
      if (emit_last) begin
        pend <= 1'b0;
      end else begin
        eidx <= eidx + EIDX_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pend && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pend && hit) begin
      recv_bit      <= bit_sel ^ fl;
      drift_state   <= zi;
      error_applied <= fl;
      last_of_block <= seen_last && emit_last;
    end
  end

endmodule

`default_nettype wire
